@@ hw/rtl/diamond_square_terrain_engine_unit_assert.svh @@
// Assertion macros for the diamond-square terrain engine.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef DIAMOND_SQUARE_TERRAIN_ENGINE_UNIT_ASSERT_SVH
`define DIAMOND_SQUARE_TERRAIN_ENGINE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Clocked check, off while reset is asserted
`define DST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset
`define DST_ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DST_ASSERT(lbl, clk, rst_n, prop, msg)
`define DST_ASSERT_CLK(lbl, clk, prop, msg)
`endif
`endif

@@ hw/rtl/dst_pkg.sv @@
// Shared types and constants of the diamond-square terrain engine.
// No dependencies; imported by every RTL module of the block.
package dst_pkg;

    // Request opcodes (tuser of the input stream)
    localparam logic [1:0] OP_GEN  = 2'd0;
    localparam logic [1:0] OP_CELL = 2'd1;
    localparam logic [1:0] OP_SAMP = 2'd2;

    // Input tdata layout, lowest field first
    localparam int SEED_LSB = 0;
    localparam int CX_LSB   = 32;
    localparam int CZ_LSB   = 39;
    localparam int WX_LSB   = 46;
    localparam int WZ_LSB   = 66;
    localparam int IN_TDATA_W = 88;

    // Random generator
    localparam logic [31:0] LCG_MUL      = 32'd1664525;
    localparam logic [31:0] LCG_INC      = 32'd1013904223;
    localparam logic [31:0] SEED_DEFAULT = 32'hC0FFEE01;

    // Terrain constants
    localparam logic [7:0]  CORNER_INIT = 8'd128;
    localparam logic [6:0]  AMP_INIT    = 7'd96;
    localparam logic [7:0]  HEIGHT_MAX  = 8'd255;
    // sum / 9 as (sum * 7282) >> 16, exact for sums of nine 8-bit cells
    localparam logic [12:0] BLUR_RECIP  = 13'd7282;
    localparam int          BLUR_SHIFT  = 16;

    // Remainder unit request and response
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [7:0]  divisor;
    } rem_req_t;

    typedef struct packed {
        logic       done;
        logic [7:0] remainder;
    } rem_rsp_t;

endpackage

@@ hw/rtl/dst_rem_unit.sv @@
// Bit-serial remainder unit: 32-bit dividend modulo 8-bit divisor, one bit per cycle.
// Depends on dst_pkg for the request and response structs.
module dst_rem_unit
    import dst_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  rem_req_t req,
    output rem_rsp_t rsp
);

    logic [31:0] dvd_reg;
    logic [7:0]  div_reg;
    logic [7:0]  rem_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [8:0]  trial;
    logic        fits;
    logic [7:0]  rem_next;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[31]};
        fits     = (trial >= {1'b0, div_reg});
        rem_next = fits ? 8'(trial - {1'b0, div_reg}) : trial[7:0];
    end

    // Control: load on start, iterate 32 times, flag done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd31;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            div_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

@@ hw/rtl/dst_lerp.sv @@
// Shared linear interpolation step: h0 + floor((h1 - h0) * t / 2^FRAC_BITS), registered.
// Depends on dst_pkg; used three times per bilinear sample.
module dst_lerp
    import dst_pkg::*;
#(
    parameter int HW        = 12,
    parameter int FRAC_BITS = 14
)
(
    input  logic                 clk,
    input  logic                 go,
    input  logic [HW-1:0]        h0,
    input  logic [HW-1:0]        h1,
    input  logic [FRAC_BITS-1:0] t,
    output logic [HW-1:0]        result
);

    localparam int PW = HW + FRAC_BITS + 2;

    logic signed [HW:0]        diff;
    logic signed [PW-1:0]      prod;
    logic signed [PW-1:0]      scaled;
    logic signed [PW-1:0]      base;
    logic signed [PW-1:0]      total;
    logic        [HW-1:0]      result_reg;

    // Signed difference times unsigned fraction, floor by arithmetic shift
    always_comb
    begin
        diff   = $signed({1'b0, h1}) - $signed({1'b0, h0});
        prod   = PW'(diff * $signed({1'b0, t}));
        scaled = prod >>> FRAC_BITS;
        base   = $signed(PW'(h0));
        total  = base + scaled;
    end

    // Hold the result until the next step
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            result_reg <= total[HW-1:0];
        end
    end

    assign result = result_reg;

endmodule

@@ hw/rtl/diamond_square_terrain_engine_unit.sv @@
// Top level of the diamond-square terrain engine: sequencer, height store and blur scratch.
// Depends on dst_pkg, dst_rem_unit, dst_lerp and the assertion macro header.
//
//   Channel   Dir  Handshake               Payload
//   s_axis    in   s_axis_tvalid/tready    tuser: opcode; tdata: seed, cell, world coords
//   m_axis    out  m_axis_tvalid/tready    tdata: height_value; tuser: is_sample
//
// Cell read: one store read. Sample: four store reads, then three passes through the
// shared interpolation unit. Generate: for each displaced cell, four corner reads and a
// wait on the bit-serial remainder unit for its jitter (skipped at zero amplitude); then
// a blur of nine store reads per cell and a copy back to the store. It gives no result.
// Reset: the store reads as zero until the first generate; no clearing pass runs.
// A result waiting on m_axis stalls only the next result, not the next accept.
`include "diamond_square_terrain_engine_unit_assert.svh"
module diamond_square_terrain_engine_unit
    import dst_pkg::*;
#(
    parameter int SIZE_LOG2    = 7,
    parameter int FRAC_BITS    = 14,
    parameter int CELL_SHIFT   = 6,
    parameter int HEIGHT_SHIFT = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] seed, [38:32] cell_x, [45:39] cell_z, [65:46] world_x, [85:66] world_z
    input  logic [87:0] s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] height_value
    output logic [15:0] m_axis_tdata,
    // [0] is_sample
    output logic [0:0]  m_axis_tuser
);

    localparam int N        = SIZE_LOG2;
    localparam int AW       = 2 * N;
    localparam int CELLS    = 1 << AW;
    localparam int LW       = $clog2(N + 1);
    localparam int HW       = 8 + HEIGHT_SHIFT;
    localparam int SCALE_UP = (FRAC_BITS >= CELL_SHIFT) ? FRAC_BITS - CELL_SHIFT : 0;
    localparam int SCALE_DN = (FRAC_BITS >= CELL_SHIFT) ? 0 : CELL_SHIFT - FRAC_BITS;
    localparam logic [19:0] LOW_MASK = 20'((64'd1 << CELL_SHIFT) - 64'd1);

    typedef enum logic [13:0] {
        ST_IDLE   = 14'b00000000000001,
        ST_Q_RD   = 14'b00000000000010,
        ST_Q_LA   = 14'b00000000000100,
        ST_Q_LB   = 14'b00000000001000,
        ST_Q_LR   = 14'b00000000010000,
        ST_Q_OUT  = 14'b00000000100000,
        ST_G_INIT = 14'b00000001000000,
        ST_G_RD   = 14'b00000010000000,
        ST_G_LCG  = 14'b00000100000000,
        ST_G_REM  = 14'b00001000000000,
        ST_G_WR   = 14'b00010000000000,
        ST_B_RD   = 14'b00100000000000,
        ST_B_WR   = 14'b01000000000000,
        ST_C_COPY = 14'b10000000000000
    } state_t;

    typedef enum logic [2:0] {
        PH_DIAM = 3'b001,
        PH_SQA  = 3'b010,
        PH_SQB  = 3'b100
    } phase_t;

    // Request fields
    logic [31:0] in_seed;
    logic [6:0]  in_cx;
    logic [6:0]  in_cz;
    logic [19:0] in_wx;
    logic [19:0] in_wz;

    assign in_seed = s_axis_tdata[SEED_LSB +: 32];
    assign in_cx   = s_axis_tdata[CX_LSB +: 7];
    assign in_cz   = s_axis_tdata[CZ_LSB +: 7];
    assign in_wx   = s_axis_tdata[WX_LSB +: 20];
    assign in_wz   = s_axis_tdata[WZ_LSB +: 20];

    // Control and working registers
    state_t               state_reg;
    phase_t               phase_reg;
    logic [3:0]           cnt_reg;
    logic [N-1:0]         z_reg;
    logic [N-1:0]         x_reg;
    logic [LW-1:0]        lvl_reg;
    logic [6:0]           amp_reg;
    logic [31:0]          lcg_reg;
    logic [11:0]          sum_reg;
    logic [AW:0]          cp_reg;
    logic                 store_valid_reg;
    logic                 samp_reg;
    logic [N-1:0]         qx_reg;
    logic [N-1:0]         qz_reg;
    logic [FRAC_BITS-1:0] tx_reg;
    logic [FRAC_BITS-1:0] tz_reg;
    logic [7:0]           h_reg [4];
    logic [HW-1:0]        a_reg;
    logic                 m_valid_reg;
    logic [15:0]          m_height_reg;
    logic                 m_sample_reg;

    // Memories
    logic [7:0]    hs_mem [CELLS];
    logic [7:0]    hs_rd_reg;
    logic [7:0]    sc_mem [CELLS];
    logic [7:0]    sc_rd_reg;

    logic          hs_we;
    logic [AW-1:0] hs_wa;
    logic [7:0]    hs_wd;
    logic [AW-1:0] hs_ra;
    logic          sc_we;
    logic [AW-1:0] sc_wa;
    logic [7:0]    sc_wd;
    logic [AW-1:0] sc_ra;
    logic [7:0]    rd_eff;

    // Step geometry
    logic [N:0]    step_w;
    logic [N-1:0]  step_n;
    logic [N-1:0]  half_n;
    logic [N:0]    x_add;
    logic [N:0]    z_add;
    logic [N-1:0]  gz_a;
    logic [N-1:0]  gx_a;
    logic [N-1:0]  tz_a;
    logic [N-1:0]  tx_a;
    logic [1:0]    b_row;
    logic [1:0]    b_col;
    logic [N-1:0]  bz_a;
    logic [N-1:0]  bx_a;
    logic [N-1:0]  qz_a;
    logic [N-1:0]  qx_a;

    // Arithmetic
    logic [31:0]        lcg_next;
    logic [31:0]        seed_sel;
    logic [6:0]         amp_next;
    logic signed [10:0] jit;
    logic signed [10:0] v_gen;
    logic [7:0]         v_clamp;
    logic [24:0]        blur_prod;
    logic [AW:0]        cp_dec;

    // Sample position
    logic signed [19:0] wx_s;
    logic signed [19:0] wz_s;
    logic [19:0]        gx_full;
    logic [19:0]        gz_full;
    logic [35:0]        lowx;
    logic [35:0]        lowz;
    logic [FRAC_BITS-1:0] tx_in;
    logic [FRAC_BITS-1:0] tz_in;

    // Shared units
    rem_req_t             rem_req;
    rem_rsp_t             rem_rsp;
    logic                 lerp_go;
    logic [HW-1:0]        lerp_h0;
    logic [HW-1:0]        lerp_h1;
    logic [FRAC_BITS-1:0] lerp_t;
    logic [HW-1:0]        lerp_out;

    logic                 accept;
    logic                 out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign rd_eff        = store_valid_reg ? hs_rd_reg : 8'd0;

    // Map a world position to grid cell and fraction
    always_comb
    begin
        wx_s    = $signed(in_wx);
        wz_s    = $signed(in_wz);
        gx_full = 20'(wx_s >>> CELL_SHIFT);
        gz_full = 20'(wz_s >>> CELL_SHIFT);
        lowx    = 36'(in_wx & LOW_MASK);
        lowz    = 36'(in_wz & LOW_MASK);
        tx_in   = FRAC_BITS'((lowx << SCALE_UP) >> SCALE_DN);
        tz_in   = FRAC_BITS'((lowz << SCALE_UP) >> SCALE_DN);
    end

    // Step sizes and loop increments for the current level
    always_comb
    begin
        step_w = (N + 1)'(1) << lvl_reg;
        step_n = step_w[N-1:0];
        half_n = N'(step_w >> 1);
        x_add  = {1'b0, x_reg} + step_w;
        z_add  = {1'b0, z_reg} + step_w;
    end

    // Corner reads and target cell of the current displacement
    always_comb
    begin
        gz_a = z_reg;
        gx_a = x_reg;
        tz_a = z_reg;
        tx_a = x_reg;
        unique case (phase_reg)
            PH_DIAM:
            begin
                tz_a = z_reg + half_n;
                tx_a = x_reg + half_n;
                unique case (cnt_reg[1:0])
                    2'd0: begin gz_a = z_reg;          gx_a = x_reg;          end
                    2'd1: begin gz_a = z_reg;          gx_a = x_reg + step_n; end
                    2'd2: begin gz_a = z_reg + step_n; gx_a = x_reg;          end
                    2'd3: begin gz_a = z_reg + step_n; gx_a = x_reg + step_n; end
                endcase
            end
            PH_SQA:
            begin
                tz_a = z_reg + half_n;
                tx_a = x_reg;
                unique case (cnt_reg[1:0])
                    2'd0: begin gz_a = z_reg;          gx_a = x_reg;          end
                    2'd1: begin gz_a = z_reg + step_n; gx_a = x_reg;          end
                    2'd2: begin gz_a = z_reg + half_n; gx_a = x_reg - half_n; end
                    2'd3: begin gz_a = z_reg + half_n; gx_a = x_reg + half_n; end
                endcase
            end
            PH_SQB:
            begin
                tz_a = z_reg;
                tx_a = x_reg + half_n;
                unique case (cnt_reg[1:0])
                    2'd0: begin gz_a = z_reg;          gx_a = x_reg;          end
                    2'd1: begin gz_a = z_reg;          gx_a = x_reg + step_n; end
                    2'd2: begin gz_a = z_reg - half_n; gx_a = x_reg + half_n; end
                    2'd3: begin gz_a = z_reg + half_n; gx_a = x_reg + half_n; end
                endcase
            end
            default:
            begin
                gz_a = z_reg;
                gx_a = x_reg;
            end
        endcase
    end

    // Blur neighborhood: row and column offset plus one, walked row by row
    always_comb
    begin
        unique case (cnt_reg)
            4'd0:    begin b_row = 2'd0; b_col = 2'd0; end
            4'd1:    begin b_row = 2'd0; b_col = 2'd1; end
            4'd2:    begin b_row = 2'd0; b_col = 2'd2; end
            4'd3:    begin b_row = 2'd1; b_col = 2'd0; end
            4'd4:    begin b_row = 2'd1; b_col = 2'd1; end
            4'd5:    begin b_row = 2'd1; b_col = 2'd2; end
            4'd6:    begin b_row = 2'd2; b_col = 2'd0; end
            4'd7:    begin b_row = 2'd2; b_col = 2'd1; end
            4'd8:    begin b_row = 2'd2; b_col = 2'd2; end
            default: begin b_row = 2'd1; b_col = 2'd1; end
        endcase
        bz_a = z_reg + N'(b_row) - N'(1);
        bx_a = x_reg + N'(b_col) - N'(1);
    end

    // Query corners: (z,x), (z,x+1), (z+1,x), (z+1,x+1)
    always_comb
    begin
        qz_a = qz_reg + N'(cnt_reg[1]);
        qx_a = qx_reg + N'(cnt_reg[0]);
    end

    // Displaced value and blur quotient
    always_comb
    begin
        lcg_next  = 32'(lcg_reg * LCG_MUL) + LCG_INC;
        seed_sel  = (in_seed != 32'd0) ? in_seed : SEED_DEFAULT;
        amp_next  = 7'((10'(amp_reg) * 10'd5) >> 3);
        jit       = (amp_reg == 7'd0) ? 11'sd0 :
                    $signed({3'b0, rem_rsp.remainder}) - $signed({4'b0, amp_reg});
        v_gen     = $signed({3'b0, sum_reg[9:2]}) + jit;
        if (v_gen < 11'sd0)
        begin
            v_clamp = 8'd0;
        end
        else if (v_gen > $signed({3'b0, HEIGHT_MAX}))
        begin
            v_clamp = HEIGHT_MAX;
        end
        else
        begin
            v_clamp = v_gen[7:0];
        end
        blur_prod = 25'(sum_reg) * 25'(BLUR_RECIP);
        cp_dec    = cp_reg - (AW + 1)'(1);
    end

    // Store ports
    always_comb
    begin
        hs_we = 1'b0;
        hs_wa = '0;
        hs_wd = '0;
        hs_ra = '0;
        sc_we = 1'b0;
        sc_wa = {z_reg, x_reg};
        sc_wd = blur_prod[BLUR_SHIFT +: 8];
        sc_ra = cp_reg[AW-1:0];
        priority case (1'b1)
            state_reg == ST_G_INIT:
            begin
                hs_we = 1'b1;
                hs_wd = CORNER_INIT;
            end
            state_reg == ST_G_WR:
            begin
                hs_we = 1'b1;
                hs_wa = {tz_a, tx_a};
                hs_wd = v_clamp;
            end
            state_reg == ST_C_COPY:
            begin
                hs_we = (cp_reg != '0);
                hs_wa = cp_dec[AW-1:0];
                hs_wd = sc_rd_reg;
            end
            state_reg == ST_G_RD:
            begin
                hs_ra = {gz_a, gx_a};
            end
            state_reg == ST_B_RD:
            begin
                hs_ra = {bz_a, bx_a};
            end
            state_reg == ST_B_WR:
            begin
                sc_we = 1'b1;
            end
            state_reg == ST_Q_RD:
            begin
                hs_ra = {qz_a, qx_a};
            end
            default:
            begin
                hs_ra = '0;
            end
        endcase
    end

    // Height store and blur scratch, registered reads
    always_ff @(posedge clk)
    begin
        if (hs_we)
        begin
            hs_mem[hs_wa] <= hs_wd;
        end
        hs_rd_reg <= hs_mem[hs_ra];
    end

    always_ff @(posedge clk)
    begin
        if (sc_we)
        begin
            sc_mem[sc_wa] <= sc_wd;
        end
        sc_rd_reg <= sc_mem[sc_ra];
    end

    // Remainder unit: start with the advanced generator value
    assign rem_req.start    = (state_reg == ST_G_LCG);
    assign rem_req.dividend = lcg_next;
    assign rem_req.divisor  = {amp_reg, 1'b1};

    dst_rem_unit u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .rsp   (rem_rsp)
    );

    // Interpolation operand select: two rows along x, then along z
    always_comb
    begin
        lerp_go = 1'b0;
        lerp_h0 = HW'(h_reg[0]) << HEIGHT_SHIFT;
        lerp_h1 = HW'(h_reg[1]) << HEIGHT_SHIFT;
        lerp_t  = tx_reg;
        priority case (1'b1)
            state_reg == ST_Q_LA:
            begin
                lerp_go = 1'b1;
            end
            state_reg == ST_Q_LB:
            begin
                lerp_go = 1'b1;
                lerp_h0 = HW'(h_reg[2]) << HEIGHT_SHIFT;
                lerp_h1 = HW'(h_reg[3]) << HEIGHT_SHIFT;
            end
            state_reg == ST_Q_LR:
            begin
                lerp_go = 1'b1;
                lerp_h0 = a_reg;
                lerp_h1 = lerp_out;
                lerp_t  = tz_reg;
            end
            default:
            begin
                lerp_go = 1'b0;
            end
        endcase
    end

    dst_lerp #(
        .HW        (HW),
        .FRAC_BITS (FRAC_BITS)
    ) u_lerp (
        .clk    (clk),
        .go     (lerp_go),
        .h0     (lerp_h0),
        .h1     (lerp_h1),
        .t      (lerp_t),
        .result (lerp_out)
    );

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            phase_reg       <= PH_DIAM;
            cnt_reg         <= '0;
            store_valid_reg <= 1'b0;
            lcg_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            // Drop a taken result; the output state reloads the slot itself
            if (m_valid_reg && m_axis_tready && state_reg != ST_Q_OUT)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (accept)
                    begin
                        unique case (s_axis_tuser)
                            OP_GEN:
                            begin
                                lcg_reg         <= seed_sel;
                                amp_reg         <= AMP_INIT;
                                lvl_reg         <= LW'(N);
                                z_reg           <= '0;
                                x_reg           <= '0;
                                phase_reg       <= PH_DIAM;
                                store_valid_reg <= 1'b1;
                                state_reg       <= ST_G_INIT;
                            end
                            OP_CELL:
                            begin
                                qx_reg    <= N'(in_cx);
                                qz_reg    <= N'(in_cz);
                                samp_reg  <= 1'b0;
                                state_reg <= ST_Q_RD;
                            end
                            OP_SAMP:
                            begin
                                qx_reg    <= gx_full[N-1:0];
                                qz_reg    <= gz_full[N-1:0];
                                tx_reg    <= tx_in;
                                tz_reg    <= tz_in;
                                samp_reg  <= 1'b1;
                                state_reg <= ST_Q_RD;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_Q_RD:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg != 4'd0)
                    begin
                        h_reg[cnt_reg[1:0] - 2'd1] <= rd_eff;
                    end
                    if (!samp_reg && cnt_reg == 4'd1)
                    begin
                        state_reg <= ST_Q_OUT;
                    end
                    else if (cnt_reg == 4'd4)
                    begin
                        state_reg <= ST_Q_LA;
                    end
                end
                ST_Q_LA:
                begin
                    state_reg <= ST_Q_LB;
                end
                ST_Q_LB:
                begin
                    a_reg     <= lerp_out;
                    state_reg <= ST_Q_LR;
                end
                ST_Q_LR:
                begin
                    state_reg <= ST_Q_OUT;
                end
                ST_Q_OUT:
                begin
                    // Hold until the output slot frees up
                    if (out_free)
                    begin
                        m_valid_reg  <= 1'b1;
                        m_height_reg <= samp_reg ? 16'(lerp_out) : 16'(h_reg[0]);
                        m_sample_reg <= samp_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                ST_G_INIT:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_G_RD;
                end
                ST_G_RD:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    sum_reg <= (cnt_reg == 4'd0) ? 12'd0 : sum_reg + 12'(rd_eff);
                    if (cnt_reg == 4'd4)
                    begin
                        state_reg <= (amp_reg == 7'd0) ? ST_G_WR : ST_G_LCG;
                    end
                end
                ST_G_LCG:
                begin
                    lcg_reg   <= lcg_next;
                    state_reg <= ST_G_REM;
                end
                ST_G_REM:
                begin
                    if (rem_rsp.done)
                    begin
                        state_reg <= ST_G_WR;
                    end
                end
                ST_G_WR:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_G_RD;
                    unique case (phase_reg)
                        PH_DIAM:
                        begin
                            x_reg <= x_add[N-1:0];
                            if (x_add[N])
                            begin
                                z_reg <= z_add[N-1:0];
                                if (z_add[N])
                                begin
                                    phase_reg <= PH_SQA;
                                end
                            end
                        end
                        PH_SQA:
                        begin
                            phase_reg <= PH_SQB;
                        end
                        PH_SQB:
                        begin
                            phase_reg <= PH_SQA;
                            x_reg     <= x_add[N-1:0];
                            if (x_add[N])
                            begin
                                z_reg <= z_add[N-1:0];
                                if (z_add[N])
                                begin
                                    // Level done: halve the step and damp the jitter
                                    phase_reg <= PH_DIAM;
                                    lvl_reg   <= lvl_reg - LW'(1);
                                    amp_reg   <= amp_next;
                                    if (lvl_reg == LW'(1))
                                    begin
                                        state_reg <= ST_B_RD;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            phase_reg <= PH_DIAM;
                        end
                    endcase
                end
                ST_B_RD:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    sum_reg <= (cnt_reg == 4'd0) ? 12'd0 : sum_reg + 12'(rd_eff);
                    if (cnt_reg == 4'd9)
                    begin
                        state_reg <= ST_B_WR;
                    end
                end
                ST_B_WR:
                begin
                    cnt_reg <= '0;
                    x_reg   <= x_reg + N'(1);
                    if (x_reg == {N{1'b1}})
                    begin
                        z_reg <= z_reg + N'(1);
                    end
                    if (x_reg == {N{1'b1}} && z_reg == {N{1'b1}})
                    begin
                        cp_reg    <= '0;
                        state_reg <= ST_C_COPY;
                    end
                    else
                    begin
                        state_reg <= ST_B_RD;
                    end
                end
                ST_C_COPY:
                begin
                    cp_reg <= cp_reg + (AW + 1)'(1);
                    if (cp_reg == (AW + 1)'(CELLS))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_height_reg;
    assign m_axis_tuser  = m_sample_reg;

    // A result shows up only out of the output state
    `DST_ASSERT(a_result_from_out, clk, rst_n, $rose(m_axis_tvalid) |-> $past(state_reg == ST_Q_OUT), "result raised outside output state")
    // The remainder unit answers only while the sequencer waits for it
    `DST_ASSERT(a_rem_done_waited, clk, rst_n, rem_rsp.done |-> state_reg == ST_G_REM, "remainder done while not waiting")
    // The store is never written while the block can take a request
    `DST_ASSERT(a_idle_no_write, clk, rst_n, s_axis_tready |-> !hs_we, "store written while idle")
    // A generate request starts by planting the corner
    `DST_ASSERT(a_gen_starts, clk, rst_n, (accept && s_axis_tuser == OP_GEN) |=> state_reg == ST_G_INIT, "generate did not start")

endmodule

@@ verif/tb.sv @@
// Testbench for the diamond-square terrain engine: streams generate, cell-read and
// sample requests and checks every result against an in-bench terrain predictor.
// Depends on dst_pkg and diamond_square_terrain_engine_unit.
`timescale 1ns / 100ps

module tb;
    import dst_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int GRID_LOG2 = 7;
    localparam int GRID = 1 << GRID_LOG2;
    localparam int GMASK = GRID - 1;
    localparam int CELL_SH = 6;
    localparam int FRAC_W = 14;
    localparam int HGT_SH = 4;

    typedef struct {
        logic [15:0] height;
        logic        is_samp;
    } height_rsp_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    // Predictor state
    bit [7:0]  terrain [GRID * GRID];
    bit [7:0]  blur_buf [GRID * GRID];
    bit [31:0] lcg_state;

    height_rsp_t height_q[$];
    int  err_cnt;
    bit  gaps_on;
    int  rx_hold;

    diamond_square_terrain_engine_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock, 4 ns period
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int cell_idx(int z, int x);
        return ((z & GMASK) << GRID_LOG2) | (x & GMASK);
    endfunction

    function automatic int next_jitter(int amp);
        bit [31:0] modulus;
        if (amp <= 0)
        begin
            return 0;
        end
        lcg_state = lcg_state * LCG_MUL + LCG_INC;
        modulus = 2 * amp + 1;
        return int'(lcg_state % modulus) - amp;
    endfunction

    function automatic void put_height(int z, int x, int v);
        if (v < 0)
        begin
            v = 0;
        end
        if (v > 255)
        begin
            v = 255;
        end
        terrain[cell_idx(z, x)] = v[7:0];
    endfunction

    function automatic int avg_of4(int z0, int x0, int z1, int x1,
                                   int z2, int x2, int z3, int x3);
        int s;
        s = terrain[cell_idx(z0, x0)] + terrain[cell_idx(z1, x1)]
          + terrain[cell_idx(z2, x2)] + terrain[cell_idx(z3, x3)];
        return s >> 2;
    endfunction

    // Rebuild the whole heightfield the way a generate request does
    function automatic void build_terrain(bit [31:0] seed);
        int step;
        int half;
        int amp;
        int sum;
        int avg;
        step = GRID;
        amp = 96;
        foreach (terrain[i])
        begin
            terrain[i] = 8'd0;
        end
        lcg_state = (seed != 0) ? seed : SEED_DEFAULT;
        put_height(0, 0, 128);
        while (step > 1)
        begin
            half = step >> 1;
            for (int z = 0; z < GRID; z += step)
            begin
                for (int x = 0; x < GRID; x += step)
                begin
                    avg = avg_of4(z, x, z, x + step, z + step, x, z + step, x + step);
                    put_height(z + half, x + half, avg + next_jitter(amp));
                end
            end
            for (int z = 0; z < GRID; z += step)
            begin
                for (int x = 0; x < GRID; x += step)
                begin
                    avg = avg_of4(z, x, z + step, x, z + half, x - half, z + half, x + half);
                    put_height(z + half, x, avg + next_jitter(amp));
                    avg = avg_of4(z, x, z, x + step, z - half, x + half, z + half, x + half);
                    put_height(z, x + half, avg + next_jitter(amp));
                end
            end
            step = half;
            amp = (amp * 5) >> 3;
        end
        // 3x3 wrapped box blur
        for (int z = 0; z < GRID; z++)
        begin
            for (int x = 0; x < GRID; x++)
            begin
                sum = 0;
                for (int dz = -1; dz <= 1; dz++)
                begin
                    for (int dx = -1; dx <= 1; dx++)
                    begin
                        sum += terrain[cell_idx(z + dz, x + dx)];
                    end
                end
                blur_buf[cell_idx(z, x)] = sum / 9;
            end
        end
        terrain = blur_buf;
    endfunction

    function automatic logic [15:0] bilinear_height(logic [19:0] wx, logic [19:0] wz);
        int     gx;
        int     gz;
        longint tx;
        longint tz;
        longint h00;
        longint h10;
        longint h01;
        longint h11;
        longint a;
        longint b;
        longint r;
        gx = int'($signed(wx)) >>> CELL_SH;
        gz = int'($signed(wz)) >>> CELL_SH;
        tx = longint'(wx[CELL_SH-1:0]) << (FRAC_W - CELL_SH);
        tz = longint'(wz[CELL_SH-1:0]) << (FRAC_W - CELL_SH);
        h00 = longint'(terrain[cell_idx(gz, gx)]) << HGT_SH;
        h10 = longint'(terrain[cell_idx(gz, gx + 1)]) << HGT_SH;
        h01 = longint'(terrain[cell_idx(gz + 1, gx)]) << HGT_SH;
        h11 = longint'(terrain[cell_idx(gz + 1, gx + 1)]) << HGT_SH;
        a = h00 + (((h10 - h00) * tx) >>> FRAC_W);
        b = h01 + (((h11 - h01) * tx) >>> FRAC_W);
        r = a + (((b - a) * tz) >>> FRAC_W);
        return r[15:0];
    endfunction

    // Update the predictor for one accepted request
    function automatic void predict_request(logic [1:0] op, logic [31:0] seed,
                                            logic [6:0] cx, logic [6:0] cz,
                                            logic [19:0] wx, logic [19:0] wz);
        height_rsp_t rsp;
        case (op)
            OP_GEN:
            begin
                build_terrain(seed);
            end
            OP_CELL:
            begin
                rsp.height = {8'd0, terrain[cell_idx(cz, cx)]};
                rsp.is_samp = 1'b0;
                height_q.push_back(rsp);
            end
            OP_SAMP:
            begin
                rsp.height = bilinear_height(wx, wz);
                rsp.is_samp = 1'b1;
                height_q.push_back(rsp);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic int pick_gap();
        if (!gaps_on || $urandom_range(0, 2) == 0)
        begin
            return 0;
        end
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    // Send one request and wait for its acceptance
    task automatic send_request(logic [1:0] op, logic [31:0] seed, logic [6:0] cx,
                                logic [6:0] cz, logic [19:0] wx, logic [19:0] wz);
        int  gap;
        bit  rdy;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {2'b00, wz, wx, cz, cx, seed};
        forever
        begin
            #1;
            rdy = s_axis_tready;
            @(posedge clk);
            if (rdy)
            begin
                break;
            end
            @(negedge clk);
        end
        predict_request(op, seed, cx, cz, wx, wz);
        @(negedge clk);
    endtask

    task automatic send_random_query();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
        begin
            send_request(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        else
        begin
            send_request(pick < 50 ? OP_CELL : OP_SAMP, $urandom, $urandom, $urandom,
                         $urandom, $urandom);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        wait (height_q.size() == 0);
        repeat (30) @(negedge clk);
    endtask

    // Result checker and receiver stalls
    initial
    begin
        bit          vld;
        bit          rdy;
        logic [15:0] got_h;
        logic        got_s;
        int          gap;
        height_rsp_t want;
        m_axis_tready = 1'b0;
        gap = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                rx_hold--;
                rdy = 1'b0;
            end
            else if (gap > 0)
            begin
                gap--;
                rdy = 1'b0;
            end
            else
            begin
                rdy = 1'b1;
                gap = pick_gap();
            end
            m_axis_tready <= rdy;
            #1;
            vld = m_axis_tvalid;
            got_h = m_axis_tdata;
            got_s = m_axis_tuser[0];
            @(posedge clk);
            if (vld && rdy)
            begin
                if (height_q.size() == 0)
                begin
                    $display("%0t: unexpected result height=%0d is_sample=%0d",
                             $time, got_h, got_s);
                    err_cnt++;
                end
                else
                begin
                    want = height_q.pop_front();
                    if (got_h !== want.height)
                    begin
                        $display("%0t: height_value expected %0d actual %0d",
                                 $time, want.height, got_h);
                        err_cnt++;
                    end
                    if (got_s !== want.is_samp)
                    begin
                        $display("%0t: is_sample expected %0d actual %0d",
                                 $time, want.is_samp, got_s);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // Queries before any generate, while the store still reads as zero
    task automatic test_reset_store();
        send_request(OP_CELL, 32'd0, 7'd0, 7'd0, 20'd0, 20'd0);
        send_request(OP_CELL, 32'hFFFF_FFFF, 7'd127, 7'd127, 20'hFFFFF, 20'hFFFFF);
        send_request(OP_SAMP, 32'd0, 7'd0, 7'd0, 20'h7FFFF, 20'h80000);
        drain_results();
    endtask

    // Generate with the default seed, then directed queries
    task automatic test_default_seed();
        send_request(OP_GEN, 32'd0, 7'd0, 7'd0, 20'd0, 20'd0);
        send_request(OP_CELL, 32'd0, 7'd0, 7'd0, 20'd0, 20'd0);
        send_request(OP_CELL, 32'd0, 7'd127, 7'd0, 20'd0, 20'd0);
        send_request(OP_CELL, 32'd0, 7'd0, 7'd127, 20'd0, 20'd0);
        send_request(OP_CELL, 32'd0, 7'd127, 7'd127, 20'd0, 20'd0);
        send_request(OP_CELL, 32'd0, 7'd64, 7'd64, 20'd0, 20'd0);
        // Opcode 3 leaves everything alone
        send_request(OP_NONE, 32'd5, 7'd1, 7'd1, 20'd1, 20'd1);
        send_request(OP_SAMP, 32'd0, 7'd0, 7'd0, 20'd0, 20'd0);
        send_request(OP_SAMP, 32'd0, 7'd0, 7'd0, 20'h7FFFF, 20'h7FFFF);
        send_request(OP_SAMP, 32'd0, 7'd0, 7'd0, 20'h80000, 20'h80000);
        send_request(OP_SAMP, 32'd0, 7'd0, 7'd0, 20'hFFFFF, 20'h00001);
        send_request(OP_SAMP, 32'd0, 7'd0, 7'd0, 20'd63, 20'd8191);
        send_request(OP_SAMP, 32'd0, 7'd0, 7'd0, 20'd8192, 20'hFFFC0);
        send_request(OP_SAMP, 32'd0, 7'd0, 7'd0, 20'h2AAAA, 20'h55555);
        drain_results();
    endtask

    // Long receiver stall while requests keep coming
    task automatic test_backpressure();
        rx_hold = 300;
        repeat (40) send_random_query();
        drain_results();
    endtask

    // Random seed generate followed by random queries
    task automatic test_random_traffic();
        logic [31:0] seed;
        seed = $urandom;
        if (seed == 0)
        begin
            seed = 32'h8000_0001;
        end
        send_request(OP_GEN, seed, $urandom, $urandom, $urandom, $urandom);
        for (int i = 0; i < 1850; i++)
        begin
            gaps_on = !((i / 200) % 3 == 1);
            send_random_query();
        end
        gaps_on = 1'b1;
        drain_results();
    endtask

    // Watchdog
    initial
    begin
        #30000000;
        $display("[diamond_square_terrain_engine_unit] ERROR");
        $finish;
    end

    initial
    begin
        err_cnt = 0;
        gaps_on = 1'b1;
        rx_hold = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_NONE;
        foreach (terrain[i])
        begin
            terrain[i] = 8'd0;
        end
        lcg_state = 32'd0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_store();
        test_default_seed();
        test_backpressure();
        test_random_traffic();
        if (err_cnt == 0)
        begin
            $display("[diamond_square_terrain_engine_unit] OK");
        end
        else
        begin
            $display("[diamond_square_terrain_engine_unit] ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/dst_pkg.sv
hw/rtl/dst_rem_unit.sv
hw/rtl/dst_lerp.sv
hw/rtl/diamond_square_terrain_engine_unit.sv
verif/tb.sv
